### hw/rtl/mtwt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtwt_pkg
// Types, codes and character tests shared by the markup tokenizer modules.
// ----------------------------------------------------------------------------
package mtwt_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] ChLt    = 8'h3C;  // '<'
  localparam logic [7:0] ChSlash = 8'h2F;  // '/'
  localparam logic [7:0] ChGt    = 8'h3E;  // '>'
  localparam logic [7:0] ChAmp   = 8'h26;  // '&'
  localparam logic [7:0] ChSemi  = 8'h3B;  // ';'
  localparam logic [7:0] ChDash  = 8'h2D;  // '-'
  localparam logic [7:0] ChApos  = 8'h27;  // apostrophe

  typedef enum logic [3:0] {
    ModeIdle     = 4'd0,
    ModeTagOpen  = 4'd1,
    ModeEtagFirst = 4'd2,
    ModeTagName  = 4'd3,
    ModeAmp      = 4'd4,
    ModeAmpName  = 4'd5,
    ModeWord     = 4'd6,
    ModeJoin     = 4'd7
  } scan_mode_e;

  typedef enum logic [1:0] {
    KindStart  = 2'd0,
    KindEnd    = 2'd1,
    KindWord   = 2'd2,
    KindNotice = 2'd3
  } token_kind_e;

  typedef struct packed {
    logic [7:0]  ch;
    token_kind_e kind;
    logic        tok_last;
  } result_t;

  // all results of one transaction, entry 0 first
  typedef struct packed {
    logic [1:0]        cnt;
    result_t [2:0]     res;
  } bundle_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

endpackage

### hw/rtl/mtwt_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtwt_scan
// Front end: accepts one byte a cycle while accept_i is high, tracks the scanner
// phase and builds the group of up to three token results each byte causes.
// ----------------------------------------------------------------------------
module mtwt_scan (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        in_char_i,
  input  logic              end_of_stream_i,
  output logic              push_o,
  output mtwt_pkg::bundle_t bundle_o
);

  mtwt_pkg::scan_mode_e  mode_q, mode_d;
  logic [7:0]            held_char_q, held_char_d;
  logic                  held_valid_q, held_valid_d;
  logic [7:0]            join_char_q, join_char_d;
  mtwt_pkg::token_kind_e ttype_q, ttype_d;
  logic                  discard_q, discard_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= mtwt_pkg::ModeIdle;
      held_char_q  <= '0;
      held_valid_q <= 1'b0;
      join_char_q  <= '0;
      ttype_q      <= mtwt_pkg::KindStart;
      discard_q    <= 1'b0;
    end else if (accept_i) begin
      mode_q       <= mode_d;
      held_char_q  <= held_char_d;
      held_valid_q <= held_valid_d;
      join_char_q  <= join_char_d;
      ttype_q      <= ttype_d;
      discard_q    <= discard_d;
    end
  end

  always_comb begin
    logic [7:0] c;
    logic [1:0] n;
    c            = in_char_i;
    n            = 2'd0;
    bundle_o     = '0;
    mode_d       = mode_q;
    held_char_d  = held_char_q;
    held_valid_d = held_valid_q;
    join_char_d  = join_char_q;
    ttype_d      = ttype_q;
    discard_d    = discard_q;

    if (end_of_stream_i) begin
      if ((mode_q == mtwt_pkg::ModeWord || mode_q == mtwt_pkg::ModeJoin) &&
          held_valid_q && !discard_q) begin
        bundle_o.res[n] = '{ch: held_char_q, kind: mtwt_pkg::KindWord, tok_last: 1'b1};
        n = n + 2'd1;
      end
      held_valid_d = 1'b0;
      discard_d    = 1'b0;
      mode_d       = mtwt_pkg::ModeIdle;
    end else begin
      unique case (mode_q)
        mtwt_pkg::ModeTagOpen: begin
          if (c == mtwt_pkg::ChSlash) begin
            bundle_o.res[n] = '{ch: held_char_q, kind: mtwt_pkg::KindEnd, tok_last: 1'b0};
            n = n + 2'd1;
            held_char_d  = c;
            held_valid_d = 1'b1;
            ttype_d      = mtwt_pkg::KindEnd;
            mode_d       = mtwt_pkg::ModeEtagFirst;
          end else begin
            if (!mtwt_pkg::is_alpha(c)) begin
              bundle_o.res[n] = '{ch: c, kind: mtwt_pkg::KindNotice, tok_last: 1'b1};
              n = n + 2'd1;
            end
            bundle_o.res[n] = '{ch: held_char_q, kind: mtwt_pkg::KindStart, tok_last: 1'b0};
            n = n + 2'd1;
            held_char_d  = c;
            held_valid_d = 1'b1;
            ttype_d      = mtwt_pkg::KindStart;
            mode_d       = mtwt_pkg::ModeTagName;
          end
        end
        mtwt_pkg::ModeEtagFirst, mtwt_pkg::ModeTagName: begin
          if (mtwt_pkg::is_alnum(c)) begin
            if (mode_q == mtwt_pkg::ModeEtagFirst && !mtwt_pkg::is_alpha(c)) begin
              bundle_o.res[n] = '{ch: c, kind: mtwt_pkg::KindNotice, tok_last: 1'b1};
              n = n + 2'd1;
            end
            bundle_o.res[n] = '{ch: held_char_q, kind: ttype_q, tok_last: 1'b0};
            n = n + 2'd1;
            held_char_d  = c;
            held_valid_d = 1'b1;
            mode_d       = mtwt_pkg::ModeTagName;
          end else begin
            // wrong terminator, or '>' right after '</'
            if (c != mtwt_pkg::ChGt || mode_q == mtwt_pkg::ModeEtagFirst) begin
              bundle_o.res[n] = '{ch: c, kind: mtwt_pkg::KindNotice, tok_last: 1'b1};
              n = n + 2'd1;
            end
            bundle_o.res[n] = '{ch: held_char_q, kind: ttype_q, tok_last: 1'b0};
            n = n + 2'd1;
            bundle_o.res[n] = '{ch: c, kind: ttype_q, tok_last: 1'b1};
            n = n + 2'd1;
            held_valid_d = 1'b0;
            if (c == mtwt_pkg::ChLt) begin
              held_char_d  = c;
              held_valid_d = 1'b1;
              ttype_d      = mtwt_pkg::KindStart;
              mode_d       = mtwt_pkg::ModeTagOpen;
            end else begin
              mode_d = mtwt_pkg::ModeIdle;
            end
          end
        end
        mtwt_pkg::ModeAmp, mtwt_pkg::ModeAmpName: begin
          if (mtwt_pkg::is_alpha(c)) begin
            mode_d = mtwt_pkg::ModeAmpName;
          end else begin
            if (mode_q == mtwt_pkg::ModeAmpName && c != mtwt_pkg::ChSemi) begin
              bundle_o.res[n] = '{ch: c, kind: mtwt_pkg::KindNotice, tok_last: 1'b1};
              n = n + 2'd1;
            end
            if (c == mtwt_pkg::ChLt) begin
              held_char_d  = c;
              held_valid_d = 1'b1;
              ttype_d      = mtwt_pkg::KindStart;
              mode_d       = mtwt_pkg::ModeTagOpen;
            end else begin
              mode_d = mtwt_pkg::ModeIdle;
            end
          end
        end
        mtwt_pkg::ModeWord: begin
          if (mtwt_pkg::is_alnum(c)) begin
            if (!discard_q) begin
              if (held_valid_q) begin
                bundle_o.res[n] = '{ch: held_char_q, kind: mtwt_pkg::KindWord,
                                    tok_last: 1'b0};
                n = n + 2'd1;
              end
              held_char_d  = c;
              held_valid_d = 1'b1;
              ttype_d      = mtwt_pkg::KindWord;
            end
          end else if (c == mtwt_pkg::ChDash || c == mtwt_pkg::ChApos) begin
            join_char_d = c;
            mode_d      = mtwt_pkg::ModeJoin;
          end else begin
            if (held_valid_q && !discard_q) begin
              bundle_o.res[n] = '{ch: held_char_q, kind: mtwt_pkg::KindWord,
                                  tok_last: 1'b1};
              n = n + 2'd1;
            end
            held_valid_d = 1'b0;
            discard_d    = 1'b0;
            if (c == mtwt_pkg::ChLt) begin
              held_char_d  = c;
              held_valid_d = 1'b1;
              ttype_d      = mtwt_pkg::KindStart;
              mode_d       = mtwt_pkg::ModeTagOpen;
            end else begin
              mode_d = mtwt_pkg::ModeIdle;
            end
          end
        end
        mtwt_pkg::ModeJoin: begin
          if (mtwt_pkg::is_alnum(c)) begin
            if (discard_q || !held_valid_q) begin
              discard_d    = 1'b1;
              held_valid_d = 1'b0;
            end else begin
              bundle_o.res[n] = '{ch: held_char_q, kind: mtwt_pkg::KindWord,
                                  tok_last: 1'b0};
              n = n + 2'd1;
              bundle_o.res[n] = '{ch: join_char_q, kind: mtwt_pkg::KindWord,
                                  tok_last: 1'b0};
              n = n + 2'd1;
              held_char_d  = c;
              held_valid_d = 1'b1;
              ttype_d      = mtwt_pkg::KindWord;
            end
          end else begin
            // byte after a dangling join char is swallowed
            if (held_valid_q && !discard_q) begin
              bundle_o.res[n] = '{ch: held_char_q, kind: mtwt_pkg::KindWord,
                                  tok_last: 1'b1};
              n = n + 2'd1;
            end
            held_valid_d = 1'b0;
            discard_d    = 1'b0;
          end
          mode_d = mtwt_pkg::ModeWord;
        end
        default: begin
          if (c == mtwt_pkg::ChLt) begin
            held_char_d  = c;
            held_valid_d = 1'b1;
            ttype_d      = mtwt_pkg::KindStart;
            mode_d       = mtwt_pkg::ModeTagOpen;
          end else if (c == mtwt_pkg::ChAmp) begin
            mode_d = mtwt_pkg::ModeAmp;
          end else if (mtwt_pkg::is_alnum(c)) begin
            discard_d    = 1'b0;
            held_char_d  = c;
            held_valid_d = 1'b1;
            ttype_d      = mtwt_pkg::KindWord;
            mode_d       = mtwt_pkg::ModeWord;
          end else begin
            mode_d = mtwt_pkg::ModeIdle;
          end
        end
      endcase
    end

    bundle_o.cnt = n;
  end

  assign push_o = accept_i && (bundle_o.cnt != 2'd0);

endmodule

### hw/rtl/mtwt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtwt_queue
// Short queue of result groups between the scanner and the output stage.
// ----------------------------------------------------------------------------
module mtwt_queue #(
  parameter int unsigned Depth = mtwt_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mtwt_pkg::bundle_t wdata_i,
  input  logic              pop_i,
  output mtwt_pkg::bundle_t rdata_o,
  output logic              empty_o,
  output logic              full_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  mtwt_pkg::bundle_t mem_q [Depth];
  logic [AddrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  function automatic logic [AddrW-1:0] ptr_inc(input logic [AddrW-1:0] p);
    return (p == AddrW'(Depth - 1)) ? '0 : p + AddrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i)
    else $error("queue written while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni) empty_o |-> !pop_i)
    else $error("queue read while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Depth))
    else $error("queue count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      push_i |-> wdata_i.cnt != 2'd0)
    else $error("empty result group queued");
`endif

endmodule

### hw/rtl/mtwt_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtwt_emit
// Back end: walks the queued result groups one result per cycle, while the
// output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module mtwt_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mtwt_pkg::bundle_t head_i,
  input  logic              empty_i,
  output logic              pop_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output mtwt_pkg::result_t out_res_o
);

  logic              valid_q;
  logic [1:0]        idx_q;
  mtwt_pkg::result_t res_q;
  logic              load;
  logic              take;
  logic              group_done;

  assign load       = !valid_q || !out_stall_i;
  assign take       = load && !empty_i;
  assign group_done = (idx_q == head_i.cnt - 2'd1);
  assign pop_o      = take && group_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load) begin
      valid_q <= !empty_i;
      if (take) begin
        idx_q <= group_done ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= head_i.res[idx_q];
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule

### hw/rtl/markup_tag_word_tokenizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markup_tag_word_tokenizer_unit
// Markup byte-stream tokenizer: start tags, end tags and words, with notices.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one byte per transaction,
//   or an end-of-stream mark. Output channel (out_valid_o / out_stall_i)
//   carries one token character per transaction with its kind and last flag.
//   One input byte yields zero to three results, in order.
//   A result is written into the queue when the byte that caused it is
//   accepted and moves from there into the output register once nothing
//   ahead of it is waiting.
//   The scanner takes one byte per cycle while the output keeps up; the
//   output stage delivers one result per cycle while out_stall_i is low, so
//   a byte with two or three results holds the output until each has gone
//   out. A queue of QUEUE_DEPTH result groups sits between scanner and
//   output; in_stall_o rises only when it is full.
//   Reset puts the scanner between tokens and empties the queue.
//   A stall on the output holds the result on the ports; the scanner keeps
//   taking bytes until the queue fills.
// ----------------------------------------------------------------------------
module markup_tag_word_tokenizer_unit #(
  parameter int unsigned QUEUE_DEPTH = mtwt_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  input  logic       end_of_stream_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic [1:0] token_kind_o,
  output logic       token_last_o
);

  logic              accept;
  logic              push;
  mtwt_pkg::bundle_t wr_bundle;
  mtwt_pkg::bundle_t head;
  logic              pop;
  logic              empty;
  logic              full;
  mtwt_pkg::result_t res;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  mtwt_scan u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .in_char_i       (in_char_i),
    .end_of_stream_i (end_of_stream_i),
    .push_o          (push),
    .bundle_o        (wr_bundle)
  );

  mtwt_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_bundle),
    .pop_i   (pop),
    .rdata_o (head),
    .empty_o (empty),
    .full_o  (full)
  );

  mtwt_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_res_o   (res)
  );

  assign out_char_o   = res.ch;
  assign token_kind_o = res.kind;
  assign token_last_o = res.tok_last;

endmodule

### bench/token_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_stream_checker
// Watches both channels of the markup tokenizer and checks every result.
// Each accepted input byte is run through a behavioral scanner that queues
// the token characters and notices it should cause. Each accepted result is
// compared field by field with the oldest queued entry.
// ----------------------------------------------------------------------------
module token_stream_checker
  import mtwt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] in_char_i,
  input  logic       end_of_stream_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_char_i,
  input  logic [1:0] token_kind_i,
  input  logic       token_last_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o,
  output int         notices_o
);

  localparam int ReportLimit = 10;

  result_t     expected_tokens[$];

  scan_mode_e  mode;
  logic [7:0]  held_ch;
  logic        held_ok;
  logic [7:0]  join_ch;
  token_kind_e held_kind;
  logic        discard;

  int mismatches;
  int checked;
  int notices;

  function automatic logic is_letter(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;
    return (folded >= "a") && (folded <= "z");
  endfunction

  function automatic logic is_letter_or_digit(input logic [7:0] c);
    return is_letter(c) || ((c >= "0") && (c <= "9"));
  endfunction

  task automatic add_expected(input logic [7:0] ch, input token_kind_e kind,
                              input logic is_last);
    result_t r;
    r.ch       = ch;
    r.kind     = kind;
    r.tok_last = is_last;
    expected_tokens.push_back(r);
  endtask

  task automatic hold_char(input logic [7:0] ch, input token_kind_e kind);
    held_ch   = ch;
    held_ok   = 1'b1;
    held_kind = kind;
  endtask

  task automatic end_word();
    if (held_ok && !discard) begin
      add_expected(held_ch, KindWord, 1'b1);
    end
    held_ok = 1'b0;
    discard = 1'b0;
  endtask

  // a '<' right after a token opens the next tag, anything else is dropped
  task automatic resume_after(input logic [7:0] c);
    if (c == ChLt) begin
      hold_char(c, KindStart);
      mode = ModeTagOpen;
    end else begin
      mode = ModeIdle;
    end
  endtask

  task automatic tokenize_byte(input logic [7:0] c, input logic eos);
    if (eos) begin
      if (mode == ModeWord || mode == ModeJoin) begin
        end_word();
      end
      held_ok = 1'b0;
      discard = 1'b0;
      mode    = ModeIdle;
      return;
    end
    case (mode)
      ModeTagOpen: begin
        if (c == ChSlash) begin
          add_expected(held_ch, KindEnd, 1'b0);
          hold_char(c, KindEnd);
          mode = ModeEtagFirst;
        end else begin
          if (!is_letter(c)) begin
            add_expected(c, KindNotice, 1'b1);
          end
          add_expected(held_ch, KindStart, 1'b0);
          hold_char(c, KindStart);
          mode = ModeTagName;
        end
      end
      ModeEtagFirst, ModeTagName: begin
        if (is_letter_or_digit(c)) begin
          if (mode == ModeEtagFirst && !is_letter(c)) begin
            add_expected(c, KindNotice, 1'b1);
          end
          add_expected(held_ch, held_kind, 1'b0);
          hold_char(c, held_kind);
          mode = ModeTagName;
        end else begin
          // terminator is kept in the tag; at most one notice for it
          if (c != ChGt || mode == ModeEtagFirst) begin
            add_expected(c, KindNotice, 1'b1);
          end
          add_expected(held_ch, held_kind, 1'b0);
          add_expected(c, held_kind, 1'b1);
          held_ok = 1'b0;
          resume_after(c);
        end
      end
      ModeAmp: begin
        if (is_letter(c)) begin
          mode = ModeAmpName;
        end else begin
          resume_after(c);
        end
      end
      ModeAmpName: begin
        if (!is_letter(c)) begin
          if (c != ChSemi) begin
            add_expected(c, KindNotice, 1'b1);
          end
          resume_after(c);
        end
      end
      ModeWord: begin
        if (is_letter_or_digit(c)) begin
          if (!discard) begin
            if (held_ok) begin
              add_expected(held_ch, KindWord, 1'b0);
            end
            hold_char(c, KindWord);
          end
        end else if (c == ChDash || c == ChApos) begin
          join_ch = c;
          mode    = ModeJoin;
        end else begin
          end_word();
          resume_after(c);
        end
      end
      ModeJoin: begin
        if (is_letter_or_digit(c)) begin
          // a word that starts with a join char is thrown away
          if (discard || !held_ok) begin
            discard = 1'b1;
            held_ok = 1'b0;
          end else begin
            add_expected(held_ch, KindWord, 1'b0);
            add_expected(join_ch, KindWord, 1'b0);
            hold_char(c, KindWord);
          end
        end else begin
          end_word();
        end
        mode = ModeWord;
      end
      default: begin
        if (c == ChLt) begin
          hold_char(c, KindStart);
          mode = ModeTagOpen;
        end else if (c == ChAmp) begin
          mode = ModeAmp;
        end else if (is_letter_or_digit(c)) begin
          discard = 1'b0;
          hold_char(c, KindWord);
          mode = ModeWord;
        end else begin
          mode = ModeIdle;
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      expected_tokens.delete();
      mode       = ModeIdle;
      held_ch    = 8'h00;
      held_ok    = 1'b0;
      join_ch    = 8'h00;
      held_kind  = KindStart;
      discard    = 1'b0;
      mismatches = 0;
      checked    = 0;
      notices    = 0;
    end else begin
      // results first: a byte accepted at this edge cannot have caused one yet
      if (out_valid_i && !out_stall_i) begin
        if (expected_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("%0t: unexpected result char %02h kind %0d last %0b", $time,
                     out_char_i, token_kind_i, token_last_i);
          end
        end else begin
          want = expected_tokens.pop_front();
          checked++;
          if (want.kind == KindNotice) begin
            notices++;
          end
          if (out_char_i !== want.ch || token_kind_i !== want.kind ||
              token_last_i !== want.tok_last) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
              $display("%0t: mismatch, got char %02h kind %0d last %0b,", $time,
                       out_char_i, token_kind_i, token_last_i);
              $display("    expected char %02h kind %0d last %0b",
                       want.ch, want.kind, want.tok_last);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        tokenize_byte(in_char_i, end_of_stream_i);
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_tokens.size();
    checked_o    <= checked;
    notices_o    <= notices;
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the markup tag and word tokenizer.
// A directed opening hits the tag, entity and word corner cases, then random
// well-formed markup mixed with noise and end-of-stream marks runs under three
// idle patterns on the two channels. Checking sits in token_stream_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import mtwt_pkg::*;

  localparam int PhaseItems = 80;
  localparam int QuietLimit = 1000;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_char_i;
  logic       end_of_stream_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_char_o;
  logic [1:0] token_kind_o;
  logic       token_last_o;

  int fail_count;
  int pending;
  int checked;
  int notices;

  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  int eos_sent;
  int quiet_cycles;
  int budget;

  always #4 clk_i = ~clk_i;

  markup_tag_word_tokenizer_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_char_i      (in_char_i),
    .end_of_stream_i(end_of_stream_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_char_o     (out_char_o),
    .token_kind_o   (token_kind_o),
    .token_last_o   (token_last_o)
  );

  token_stream_checker u_token_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .in_char_i      (in_char_i),
    .end_of_stream_i(end_of_stream_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_char_i     (out_char_o),
    .token_kind_i   (token_kind_o),
    .token_last_i   (token_last_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .notices_o      (notices)
  );

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // nothing accepted on either channel for too long ends the run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("watchdog: no transaction for %0d cycles", QuietLimit);
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(3) == 0) ? 8'h30 + 8'($urandom_range(9)) : rand_letter();
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  // called and returns at a falling edge
  task automatic send_byte(input logic [7:0] ch, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_char_i       <= ch;
    end_of_stream_i <= eos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    if (eos) begin
      eos_sent++;
    end
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], 1'b0);
    end
  endtask

  // one random piece of markup; bit 8 of each entry marks end of stream
  task automatic send_chunk(output int counted);
    logic [8:0] seq[$];
    int unsigned pick;
    int unsigned len;
    pick    = $urandom_range(19);
    counted = 0;
    if (pick < 7) begin
      // start tag, or end tag from pick 4 up
      seq.push_back({1'b0, ChLt});
      if (pick >= 4) begin
        seq.push_back({1'b0, ChSlash});
      end
      seq.push_back({1'b0, ($urandom_range(5) == 0) ? rand_byte() : rand_letter()});
      len = $urandom_range(3);
      repeat (len) seq.push_back({1'b0, rand_alnum()});
      seq.push_back({1'b0, ($urandom_range(4) == 0) ? rand_byte() : ChGt});
    end else if (pick < 13) begin
      if ($urandom_range(5) == 0) begin
        seq.push_back({1'b0, $urandom_range(1) ? ChDash : ChApos});
      end
      len = $urandom_range(1, 6);
      repeat (len) seq.push_back({1'b0, rand_alnum()});
      if ($urandom_range(2) == 0) begin
        seq.push_back({1'b0, $urandom_range(1) ? ChDash : ChApos});
        len = $urandom_range(4);
        repeat (len) seq.push_back({1'b0, rand_alnum()});
      end
      case ($urandom_range(4))
        0: seq.push_back({1'b0, ChLt});
        1: seq.push_back({1'b0, 8'h2E});
        2: seq.push_back({1'b0, 8'h0A});
        default: seq.push_back({1'b0, 8'h20});
      endcase
    end else if (pick < 15) begin
      seq.push_back({1'b0, ChAmp});
      len = $urandom_range(4);
      repeat (len) seq.push_back({1'b0, rand_letter()});
      seq.push_back({1'b0, ($urandom_range(3) == 0) ? rand_byte() : ChSemi});
    end else if (pick < 17) begin
      len = $urandom_range(1, 3);
      repeat (len) seq.push_back({1'b0, 8'h20});
    end else if (pick < 19) begin
      len = $urandom_range(1, 4);
      repeat (len) seq.push_back({1'b0, rand_byte()});
    end else begin
      seq.push_back({1'b1, rand_byte()});
    end
    counted = seq.size();
    foreach (seq[i]) begin
      send_byte(seq[i][7:0], seq[i][8]);
    end
  endtask

  task automatic run_random(input int items);
    int counted;
    budget = items;
    while (budget > 0) begin
      send_chunk(counted);
      budget -= counted;
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_char_i       = 8'h00;
    end_of_stream_i = 1'b0;
    out_stall_i     = 1'b0;
    send_idle_pct   = 38;
    recv_idle_pct   = 67;
    items_sent      = 0;
    eos_sent        = 0;
    quiet_cycles    = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // bad tag start on '<', '<' terminator reopening a tag, digit after '</'
    send_text("<<b</9>&a");
    // unclosed entity ended by a high byte
    send_byte(8'hFF, 1'b0);
    // joined word, join char before a space, word led by a join char
    send_text("x-y' 'z");
    send_byte(8'h00, 1'b0);
    // '>' straight after '</', then a word flushed by end of stream
    send_text("</>Z");
    send_byte(8'h00, 1'b1);
    // open tag dropped at end of stream
    send_text("<q");
    send_byte(8'hA5, 1'b1);

    run_random(PhaseItems);
    send_idle_pct = 67;
    recv_idle_pct = 38;
    run_random(PhaseItems);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PhaseItems);
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("tokenizer run: %0d input bytes incl. %0d end-of-stream marks, %0d results",
             items_sent, eos_sent, checked);
    $display("  (%0d notices) under sender/receiver idle 38/67, 67/38 and none",
             notices);
    if (pending != 0) begin
      $display("%0d expected results never arrived", pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
